FILE: src/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared widths, reset values, register indexes and the control/status
// structs used between the relay timer controller and datapath.
// ----------------------------------------------------------------------------
package rrt_pkg;

  // Default generic values
  localparam int TIME_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths
  localparam int SUM_BITS      = 24;
  localparam int SAMPLE_BITS   = 16;
  localparam int NUM_BITS      = 8;
  localparam int GAP_BITS      = 16;
  localparam int TOTAL_BITS    = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  // Configuration reset values
  localparam logic [GAP_BITS-1:0]   OFF_GAP_RESET   = 16'd250;
  localparam logic [TOTAL_BITS-1:0] RUN_TOTAL_RESET = 8'd10;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_OFF_GAP   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RUN_TOTAL = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic step;   // apply one request to the timer state
    logic emit;   // move the pending result into the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic avg_needed;  // the request being taken ends the measurement
    logic div_busy;    // average divider still iterating
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

endpackage

FILE: src/rrt_div.sv
// ----------------------------------------------------------------------------
// rrt_div
// Restoring divider, one quotient bit per cycle, for the final average.
// ----------------------------------------------------------------------------
module rrt_div #(
  parameter int DIVIDEND_BITS = rrt_pkg::SUM_BITS,
  parameter int DIVISOR_BITS  = rrt_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     busy,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo_r, quo_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0]  dvs_r;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_BITS'(DIVIDEND_BITS);
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[DIVIDEND_BITS-2:0], fits};
      rem_nxt = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Hold the step counter under reset; operands need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

FILE: src/rrt_ctrl.sv
// ----------------------------------------------------------------------------
// rrt_ctrl
// Sequencer: take a request, wait out the average divider when the run
// series ends, then hand the result to the output register.
// ----------------------------------------------------------------------------
module rrt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrt_pkg::dp_stat_t  stat,
  output rrt_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = stat.avg_needed ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/rrt_dp.sv
// ----------------------------------------------------------------------------
// rrt_dp
// Timer state, configuration registers, per-tick update, average divider
// and the output register.
// ----------------------------------------------------------------------------
module rrt_dp #(
  parameter int TIME_BITS  = rrt_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = rrt_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rrt_pkg::ctrl_cmd_t                 cmd,
  output rrt_pkg::dp_stat_t                  stat,
  input  logic                               cfg_we,
  input  logic [rrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rrt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               in_contact_fall,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_relay_drive,
  output logic                               out_sample_valid,
  output logic [rrt_pkg::SAMPLE_BITS-1:0]    out_sample_ms,
  output logic [rrt_pkg::NUM_BITS-1:0]       out_sample_number,
  output logic                               out_average_valid,
  output logic [rrt_pkg::SAMPLE_BITS-1:0]    out_average_ms,
  output logic                               out_finished
);

  localparam int SB = rrt_pkg::SUM_BITS;
  localparam int MB = rrt_pkg::SAMPLE_BITS;
  localparam int NB = rrt_pkg::NUM_BITS;
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SB-1:0]         SUM_MAX   = '1;
  localparam logic [MB-1:0]         SAMPLE_MAX = '1;

  // Configuration
  logic [rrt_pkg::GAP_BITS-1:0]   off_gap_r;
  logic [rrt_pkg::TOTAL_BITS-1:0] run_total_r;

  // Timer state
  logic                  relay_on_r, relay_on_nxt;
  logic [TIME_BITS-1:0]  off_ticks_r, off_ticks_nxt;
  logic [TIME_BITS-1:0]  on_ticks_r, on_ticks_nxt;
  logic [COUNT_BITS-1:0] runs_done_r, runs_done_nxt;
  logic [SB-1:0]         time_sum_r, time_sum_nxt;
  logic                  stopped_r, stopped_nxt;

  // Per-tick result fields
  logic                         s_valid;
  logic [MB-1:0]                s_ms;
  logic [rrt_pkg::NUM_BITS-1:0] s_num;
  logic                         a_valid;

  // Pending result, waiting for the divider and the output slot
  logic                         res_relay_r;
  logic                         res_s_valid_r;
  logic [MB-1:0]                res_s_ms_r;
  logic [rrt_pkg::NUM_BITS-1:0] res_s_num_r;
  logic                         res_a_valid_r;
  logic                         res_fin_r;
  logic                         div_zero_r;

  // Output register
  logic                         out_valid_r;
  logic                         out_relay_r;
  logic                         out_s_valid_r;
  logic [MB-1:0]                out_s_ms_r;
  logic [rrt_pkg::NUM_BITS-1:0] out_s_num_r;
  logic                         out_a_valid_r;
  logic [MB-1:0]                out_a_ms_r;
  logic                         out_fin_r;

  logic          div_busy;
  logic [SB-1:0] quotient;
  logic [MB-1:0] avg_ms;

  // Advance the timer by one tick
  always_comb begin
    logic [31:0] on_ext;
    logic [SB:0] sum_ext;
    relay_on_nxt  = relay_on_r;
    off_ticks_nxt = off_ticks_r;
    on_ticks_nxt  = on_ticks_r;
    runs_done_nxt = runs_done_r;
    time_sum_nxt  = time_sum_r;
    stopped_nxt   = stopped_r;
    s_valid       = 1'b0;
    s_ms          = '0;
    s_num         = '0;
    a_valid       = 1'b0;
    on_ext        = '0;
    sum_ext       = '0;
    if (!stopped_r) begin
      // Count ticks of the current phase
      if (relay_on_r) begin
        if (on_ticks_r != TIME_MAX) begin
          on_ticks_nxt = on_ticks_r + 1'b1;
        end
      end else if (off_ticks_r != TIME_MAX) begin
        off_ticks_nxt = off_ticks_r + 1'b1;
      end
      // Switch on once the off gap has elapsed
      if (!relay_on_nxt && (32'(off_ticks_nxt) >= 32'(off_gap_r))) begin
        relay_on_nxt = 1'b1;
        on_ticks_nxt = '0;
      end
      // First contact edge while on ends the run
      if (relay_on_nxt && in_contact_fall) begin
        on_ext = 32'(on_ticks_nxt);
        s_ms   = (on_ext > 32'(SAMPLE_MAX)) ? SAMPLE_MAX : on_ext[MB-1:0];
        if (runs_done_r != COUNT_MAX) begin
          runs_done_nxt = runs_done_r + 1'b1;
        end
        sum_ext       = {1'b0, time_sum_r} + (SB + 1)'(s_ms);
        time_sum_nxt  = sum_ext[SB] ? SUM_MAX : sum_ext[SB-1:0];
        relay_on_nxt  = 1'b0;
        off_ticks_nxt = '0;
        s_valid       = 1'b1;
        s_num         = NB'(runs_done_nxt);
      end
      // Stop after the set number of runs
      if (32'(runs_done_nxt) >= 32'(run_total_r)) begin
        a_valid     = 1'b1;
        stopped_nxt = 1'b1;
      end
    end
  end

  // Timer state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_gap_r   <= rrt_pkg::OFF_GAP_RESET;
      run_total_r <= rrt_pkg::RUN_TOTAL_RESET;
      relay_on_r  <= 1'b0;
      off_ticks_r <= '0;
      on_ticks_r  <= '0;
      runs_done_r <= '0;
      time_sum_r  <= '0;
      stopped_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rrt_pkg::REG_OFF_GAP:   off_gap_r   <= cfg_wdata[rrt_pkg::GAP_BITS-1:0];
          rrt_pkg::REG_RUN_TOTAL: run_total_r <= cfg_wdata[rrt_pkg::TOTAL_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        relay_on_r  <= relay_on_nxt;
        off_ticks_r <= off_ticks_nxt;
        on_ticks_r  <= on_ticks_nxt;
        runs_done_r <= runs_done_nxt;
        time_sum_r  <= time_sum_nxt;
        stopped_r   <= stopped_nxt;
      end
    end
  end

  // Capture the result of the request just taken
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res_relay_r   <= relay_on_nxt;
      res_s_valid_r <= s_valid;
      res_s_ms_r    <= s_ms;
      res_s_num_r   <= s_num;
      res_a_valid_r <= a_valid;
      res_fin_r     <= stopped_nxt;
      div_zero_r    <= (runs_done_nxt == '0);
    end
  end

  // Average: sum over runs divided by the run count in the iterative divider
  rrt_div #(
    .DIVIDEND_BITS (SB),
    .DIVISOR_BITS  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.step && a_valid),
    .dividend (time_sum_nxt),
    .divisor  (runs_done_nxt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Cap the mean at the sample range; no runs gives zero
  assign avg_ms = (!res_a_valid_r || div_zero_r) ? '0 :
                  ((quotient[SB-1:MB] != '0) ? SAMPLE_MAX : quotient[MB-1:0]);

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_relay_r   <= res_relay_r;
      out_s_valid_r <= res_s_valid_r;
      out_s_ms_r    <= res_s_ms_r;
      out_s_num_r   <= res_s_num_r;
      out_a_valid_r <= res_a_valid_r;
      out_a_ms_r    <= avg_ms;
      out_fin_r     <= res_fin_r;
    end
  end

  assign stat.avg_needed = a_valid;
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_relay_drive   = out_relay_r;
  assign out_sample_valid  = out_s_valid_r;
  assign out_sample_ms     = out_s_ms_r;
  assign out_sample_number = out_s_num_r;
  assign out_average_valid = out_a_valid_r;
  assign out_average_ms    = out_a_ms_r;
  assign out_finished      = out_fin_r;

  // Once stopped, the block stays stopped
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared");

  // Run count never goes back
  a_runs_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> runs_done_r >= $past(runs_done_r))
    else $error("run count decreased");

  // No new request while the divider works
  a_no_step_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !div_busy)
    else $error("request taken during divide");

  // Emit never overwrites an untaken result
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

endmodule

FILE: src/relay_response_timer.sv
// ----------------------------------------------------------------------------
// relay_response_timer
// Measures relay activation time over a series of runs and reports the mean.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    contact_fall (one tick per request)
//   out_     output     out_valid/out_ready  relay, sample, average, finished
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A request holds the block from its accepting cycle in ST_IDLE until ST_EMIT
// loads its result into the output register. The request that ends the
// series first waits in ST_DIV while the one-bit-per-cycle divider works out
// the average, then loads its result from ST_EMIT.
// A new request is accepted while a result waits in the output register; a
// waiting result then stalls the load and the acceptance after it. Reset is
// synchronous and active low, and restores the off gap of 250 ticks and the
// run total of 10.
// ----------------------------------------------------------------------------
module relay_response_timer #(
  parameter int TIME_BITS  = rrt_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = rrt_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rrt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_contact_fall,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_relay_drive,
  output logic                               out_sample_valid,
  output logic [rrt_pkg::SAMPLE_BITS-1:0]    out_sample_ms,
  output logic [rrt_pkg::NUM_BITS-1:0]       out_sample_number,
  output logic                               out_average_valid,
  output logic [rrt_pkg::SAMPLE_BITS-1:0]    out_average_ms,
  output logic                               out_finished
);

  rrt_pkg::ctrl_cmd_t cmd;
  rrt_pkg::dp_stat_t  stat;

  // Sequence requests
  rrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Timer state and arithmetic
  rrt_dp #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_contact_fall   (in_contact_fall),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_relay_drive   (out_relay_drive),
    .out_sample_valid  (out_sample_valid),
    .out_sample_ms     (out_sample_ms),
    .out_sample_number (out_sample_number),
    .out_average_valid (out_average_valid),
    .out_average_ms    (out_average_ms),
    .out_finished      (out_finished)
  );

endmodule

FILE: verif/tb_relay_response_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relay_response_timer
// Self-checking bench for the relay activation timer. A queue-fed driver
// offers one millisecond tick per request, a clocked monitor compares every
// result field against a cycle-free model of the timer kept in the bench.
// Covers reset defaults, ignored register slots, edges while off and on the
// switch-on tick, random gap and edge mixes, a stretch with no idling, a
// long receiver hold-off, and the stop either by the last sample or by
// lowering the run total while the relay is on.
// ----------------------------------------------------------------------------
module tb_relay_response_timer;

  localparam int          CLK_HALF      = 6;
  localparam int          CYCLE_LIMIT   = 2_000_000;
  localparam int          RANDOM_TICKS  = 700;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          CALM_FROM     = 300;
  localparam int          CALM_TO       = 450;
  localparam int          TIME_W        = rrt_pkg::TIME_BITS_DEF;
  localparam int          COUNT_W       = rrt_pkg::COUNT_BITS_DEF;
  localparam int          CFG_W         = rrt_pkg::CFG_DATA_BITS;
  localparam int          SUM_W         = rrt_pkg::SUM_BITS;
  localparam int          MS_W          = rrt_pkg::SAMPLE_BITS;
  // Register slots past the last defined register
  localparam logic [rrt_pkg::CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [rrt_pkg::CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic                            relay_drive;
    logic                            sample_valid;
    logic [rrt_pkg::SAMPLE_BITS-1:0] sample_ms;
    logic [rrt_pkg::NUM_BITS-1:0]    sample_number;
    logic                            average_valid;
    logic [rrt_pkg::SAMPLE_BITS-1:0] average_ms;
    logic                            finished;
  } tick_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [rrt_pkg::CFG_IDX_BITS-1:0]  cfg_index = rrt_pkg::REG_OFF_GAP;
  logic [rrt_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_contact_fall = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_relay_drive;
  logic                              out_sample_valid;
  logic [rrt_pkg::SAMPLE_BITS-1:0]   out_sample_ms;
  logic [rrt_pkg::NUM_BITS-1:0]      out_sample_number;
  logic                              out_average_valid;
  logic [rrt_pkg::SAMPLE_BITS-1:0]   out_average_ms;
  logic                              out_finished;

  relay_response_timer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_contact_fall   (in_contact_fall),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_relay_drive   (out_relay_drive),
    .out_sample_valid  (out_sample_valid),
    .out_sample_ms     (out_sample_ms),
    .out_sample_number (out_sample_number),
    .out_average_valid (out_average_valid),
    .out_average_ms    (out_average_ms),
    .out_finished      (out_finished)
  );

  // Ticks waiting to be offered, and results owed by the block
  bit           tick_q[$];
  tick_result_t expected_q[$];

  // Timer model: configuration and state
  logic [rrt_pkg::GAP_BITS-1:0]   gap_cfg    = rrt_pkg::OFF_GAP_RESET;
  logic [rrt_pkg::TOTAL_BITS-1:0] total_cfg  = rrt_pkg::RUN_TOTAL_RESET;
  logic                           relay_is_on = 1'b0;
  logic [TIME_W-1:0]              off_count  = '0;
  logic [TIME_W-1:0]              on_count   = '0;
  logic [COUNT_W-1:0]             runs       = '0;
  logic [SUM_W-1:0]               time_total = '0;
  logic                           halted     = 1'b0;

  int  mismatches   = 0;
  int  results_seen = 0;
  int  cycles       = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  hold_arm     = 1'b0;
  bit  calm         = 1'b0;

  // Clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Advance the timer model by one tick and return the result it yields
  function automatic tick_result_t advance_tick(input logic fall);
    tick_result_t     r;
    logic [SUM_W:0]   wide_sum;
    logic [SUM_W-1:0] mean;
    r = '0;
    if (!halted) begin
      if (relay_is_on) begin
        if (on_count != '1) on_count = on_count + 1'b1;
      end else begin
        if (off_count != '1) off_count = off_count + 1'b1;
      end
      if (!relay_is_on && off_count >= gap_cfg) begin
        relay_is_on = 1'b1;
        on_count    = '0;
      end
      // first contact edge while on closes the run
      if (relay_is_on && fall) begin
        if (runs != '1) runs = runs + 1'b1;
        wide_sum    = {1'b0, time_total} + (SUM_W + 1)'(on_count);
        time_total  = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
        relay_is_on = 1'b0;
        off_count   = '0;
        r.sample_valid  = 1'b1;
        r.sample_ms     = (on_count > {MS_W{1'b1}}) ? '1 : on_count;
        r.sample_number = runs;
      end
      if (runs >= total_cfg) begin
        mean = (runs != 0) ? time_total / runs : '0;
        r.average_valid = 1'b1;
        r.average_ms    = (mean > {MS_W{1'b1}}) ? '1 : mean[MS_W-1:0];
        halted = 1'b1;
      end
    end
    r.relay_drive = relay_is_on;
    r.finished    = halted;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %0d expected %0d",
                              results_seen, name, got, want));
  endtask

  // Driver: offer queued ticks, hold the request until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(advance_tick(in_contact_fall));
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          in_valid        <= 1'b1;
          in_contact_fall <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off once armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // Monitor: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_q.pop_front();
        check_field("relay_drive",   32'(out_relay_drive),   32'(want.relay_drive));
        check_field("sample_valid",  32'(out_sample_valid),  32'(want.sample_valid));
        check_field("sample_ms",     32'(out_sample_ms),     32'(want.sample_ms));
        check_field("sample_number", 32'(out_sample_number), 32'(want.sample_number));
        check_field("average_valid", 32'(out_average_valid), 32'(want.average_valid));
        check_field("average_ms",    32'(out_average_ms),    32'(want.average_ms));
        check_field("finished",      32'(out_finished),      32'(want.finished));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Wait until every queued tick is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [rrt_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [rrt_pkg::CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rrt_pkg::REG_OFF_GAP) gap_cfg = value[rrt_pkg::GAP_BITS-1:0];
    else if (idx == rrt_pkg::REG_RUN_TOTAL) total_cfg = value[rrt_pkg::TOTAL_BITS-1:0];
  endtask

  task automatic run_phase(input int count, input int fall_pct);
    repeat (count) tick_q.push_back($urandom_range(0, 99) < fall_pct);
    wait_drained();
  endtask

  // Stimulus sequence
  initial begin
    int                                random_sent;
    int                                count;
    int                                pct;
    int                                tries;
    logic [rrt_pkg::CFG_DATA_BITS-1:0] gap;
    random_sent = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: long off gap, edges while off are ignored
    tick_q = '{1'b1, 1'b0, 1'b1};
    wait_drained();

    // Spare register slots must not disturb anything
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    write_reg(rrt_pkg::REG_OFF_GAP, '0);
    write_reg(rrt_pkg::REG_RUN_TOTAL, 16'd255);

    // Zero gap: edge on the switch-on tick gives a zero sample
    tick_q = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
    wait_drained();
    write_reg(rrt_pkg::REG_OFF_GAP, 16'd1);
    tick_q = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    wait_drained();
    write_reg(rrt_pkg::REG_OFF_GAP, 16'd3);
    tick_q = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    wait_drained();

    // Random gaps and edge densities, keeping clear of the run total
    while (random_sent < RANDOM_TICKS && runs + 60 < total_cfg) begin
      if ($urandom_range(0, 9) == 0) gap = CFG_W'($urandom_range(0, 1));
      else gap = CFG_W'($urandom_range(2, 24));
      write_reg(rrt_pkg::REG_OFF_GAP, gap);
      case ($urandom_range(0, 3))
        0:       pct = 12;
        1:       pct = 25;
        2:       pct = 50;
        default: pct = 80;
      endcase
      count = $urandom_range(30, 60);
      if (random_sent >= 100) hold_arm = 1'b1;
      // one stretch with no idling on either side
      calm = (random_sent >= CALM_FROM && random_sent < CALM_TO);
      run_phase(count, pct);
      random_sent += count;
    end
    calm = 1'b0;

    write_reg(rrt_pkg::REG_OFF_GAP, CFG_W'($urandom_range(0, 8)));
    if ($urandom_range(0, 1) == 1) begin
      // Stop on the next sample
      write_reg(rrt_pkg::REG_RUN_TOTAL, CFG_W'(runs + 1'b1));
      tries = 0;
      while (!halted && tries < 200) begin
        run_phase(10, 30);
        tries++;
      end
    end else begin
      // Lower the run total while the relay is on: it must stay on, frozen
      tries = 0;
      while (!relay_is_on && tries < 100) begin
        run_phase(1, 0);
        tries++;
      end
      write_reg(rrt_pkg::REG_RUN_TOTAL, 16'd1);
      run_phase(1, 0);
    end
    // Ticks after the stop change nothing
    run_phase(8, 50);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
